// File: design/quadrature_angle_tracker_defines.svh
// Assertion macros used by the tracker design file.
`ifndef QUADRATURE_ANGLE_TRACKER_DEFINES_SVH
`define QUADRATURE_ANGLE_TRACKER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define QAT_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition in one cycle that forces another in the next cycle.
`define QAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/qat_pkg.sv
`default_nettype none

package qat_pkg;

	localparam int SLOTS_PER_REV   = 112;
	localparam int PHASES_PER_SLOT = 4;
	localparam int DEGREES_PER_REV = 360;
	localparam int ANGLE_SCALE     = 10;
	localparam int DIGIT_BASE      = 10;
	localparam int COUNTS_PER_REV  = SLOTS_PER_REV * PHASES_PER_SLOT;
	localparam int HALF_REV        = COUNTS_PER_REV / 2;

	localparam int COUNT_W    = 10;
	localparam int STEP_W     = COUNT_W + 1;
	localparam int DEGREES_W  = 9;
	localparam int DEG_MAG_W  = 8;
	localparam int TENTHS_W   = 4;
	localparam int PHASE_W    = 3;
	localparam int MAG_W      = 8;
	localparam int ANGLE_TABLE_DEPTH = 2 ** MAG_W;

	// Phase codes; zero means no phase has been sampled yet.
	localparam logic [PHASE_W-1:0] PHASE_NONE = 3'd0;
	localparam logic [PHASE_W-1:0] PHASE_1    = 3'd1;
	localparam logic [PHASE_W-1:0] PHASE_2    = 3'd2;
	localparam logic [PHASE_W-1:0] PHASE_3    = 3'd3;
	localparam logic [PHASE_W-1:0] PHASE_4    = 3'd4;

	typedef struct packed {
		logic [DEG_MAG_W-1:0] deg_mag;
		logic [TENTHS_W-1:0]  tenths;
	} angle_entry_t;

	typedef angle_entry_t [ANGLE_TABLE_DEPTH-1:0] angle_table_t;

	function automatic logic [PHASE_W-1:0] phase_of(input logic a, input logic b);
		logic [PHASE_W-1:0] p;
		unique case ({a, b})
			2'b00:   p = PHASE_1;
			2'b01:   p = PHASE_2;
			2'b11:   p = PHASE_3;
			default: p = PHASE_4;
		endcase
		return p;
	endfunction

	function automatic logic [PHASE_W-1:0] phase_before(input logic [PHASE_W-1:0] p);
		return (p == PHASE_1) ? PHASE_4 : p - PHASE_W'(1);
	endfunction

	function automatic logic [PHASE_W-1:0] phase_after(input logic [PHASE_W-1:0] p);
		return (p == PHASE_4) ? PHASE_1 : p + PHASE_W'(1);
	endfunction

	// Angle of a folded count magnitude, in tenths of a degree truncated toward zero,
	// split into whole degrees and the tenths digit. Evaluated at elaboration.
	function automatic angle_table_t build_angle_table();
		angle_table_t tbl;
		int scaled;
		for (int i = 0; i < ANGLE_TABLE_DEPTH; i++) begin
			scaled = (i * DEGREES_PER_REV * ANGLE_SCALE) / COUNTS_PER_REV;
			tbl[i].deg_mag = DEG_MAG_W'(scaled / ANGLE_SCALE);
			tbl[i].tenths  = TENTHS_W'(scaled % DIGIT_BASE);
		end
		return tbl;
	endfunction

	localparam angle_table_t ANGLE_TABLE = build_angle_table();

endpackage

`default_nettype wire

// File: design/quadrature_angle_tracker.sv
// Quadrature angle tracker: x4 decoder for an A/B encoder with a reference pulse.
// Input channel: in_valid / in_stall with chan_a, chan_b and ref_pulse. Each
// transaction is one sample of the encoder pins. Output channel: out_valid /
// out_stall with position_count, angle_degrees, angle_tenths and is_calibrated.
// Every input transaction yields exactly one output transaction, in order.
// A sample is registered in the input stage, decoded in one pass and written to
// the result register. Throughput is one transaction per cycle while the receiver
// does not stall; the single decode pass (phase compare, count wrap, fold and an
// angle table lookup) sets that figure.
// When the receiver stalls, the result register holds its contents, the input
// stage keeps its sample and in_stall rises only if both stages are full, so one
// further sample can still be taken while a result waits.
// The configuration port (cfg_we, cfg_wdata) writes ref_enable; it is meant to be
// written while no transaction is in flight.
// Asynchronous reset (arst_n low) empties both stages, clears the count, the
// previous phase (no phase seen) and the calibrated flag, and sets ref_enable.
`default_nettype none
`include "quadrature_angle_tracker_defines.svh"

module quadrature_angle_tracker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic                              cfg_wdata,
	input  wire logic                              in_valid,
	output      logic                              in_stall,
	input  wire logic                              chan_a,
	input  wire logic                              chan_b,
	input  wire logic                              ref_pulse,
	output      logic                              out_valid,
	input  wire logic                              out_stall,
	output      logic signed [qat_pkg::COUNT_W-1:0]   position_count,
	output      logic signed [qat_pkg::DEGREES_W-1:0] angle_degrees,
	output      logic        [qat_pkg::TENTHS_W-1:0]  angle_tenths,
	output      logic                              is_calibrated
);

	// Configuration and tracker state.
	logic                               ref_enable_q;
	logic [qat_pkg::PHASE_W-1:0]        prev_phase_q;
	logic signed [qat_pkg::COUNT_W-1:0] pos_count_q;
	logic                               calibrated_q;

	// Input stage.
	logic valid_s1;
	logic chan_a_s1;
	logic chan_b_s1;
	logic ref_pulse_s1;

	// Result stage.
	logic                                 valid_s2;
	logic signed [qat_pkg::COUNT_W-1:0]   position_count_s2;
	logic signed [qat_pkg::DEGREES_W-1:0] angle_degrees_s2;
	logic        [qat_pkg::TENTHS_W-1:0]  angle_tenths_s2;
	logic                                 is_calibrated_s2;

	logic in_accept;
	logic adv_s1;

	logic [qat_pkg::PHASE_W-1:0]          cur_phase;
	logic signed [qat_pkg::STEP_W-1:0]    stepped;
	logic signed [qat_pkg::STEP_W-1:0]    wrapped;
	logic signed [qat_pkg::COUNT_W-1:0]   next_count;
	logic                                 next_calibrated;
	logic signed [qat_pkg::STEP_W-1:0]    folded;
	logic signed [qat_pkg::STEP_W-1:0]    folded_abs;
	logic [qat_pkg::MAG_W-1:0]            fold_mag;
	qat_pkg::angle_entry_t                angle_entry;
	logic signed [qat_pkg::DEGREES_W-1:0] deg_unsigned;
	logic signed [qat_pkg::DEGREES_W-1:0] next_degrees;

	// The input stage moves on whenever the result register is empty or being taken.
	assign adv_s1    = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && valid_s2 && out_stall;
	assign in_accept = in_valid && !in_stall;

	// Phase step: forward adds one, backward subtracts one, a repeat or a skipped
	// phase leaves the count alone. The first sample has no neighbor and never steps.
	always_comb begin
		cur_phase = qat_pkg::phase_of(chan_a_s1, chan_b_s1);
		stepped   = qat_pkg::STEP_W'(pos_count_q);
		if (prev_phase_q == qat_pkg::phase_before(cur_phase)) begin
			stepped = qat_pkg::STEP_W'(pos_count_q) + qat_pkg::STEP_W'(1);
		end else if (prev_phase_q == qat_pkg::phase_after(cur_phase)) begin
			stepped = qat_pkg::STEP_W'(pos_count_q) - qat_pkg::STEP_W'(1);
		end

		// Truncating remainder: only a full revolution either way can be reached.
		if (stepped == qat_pkg::STEP_W'(qat_pkg::COUNTS_PER_REV)
				|| stepped == -qat_pkg::STEP_W'(qat_pkg::COUNTS_PER_REV)) begin
			wrapped = '0;
		end else begin
			wrapped = stepped;
		end

		// An enabled reference pulse wins over the step taken in the same sample.
		if (ref_pulse_s1 && ref_enable_q) begin
			next_count      = '0;
			next_calibrated = 1'b1;
		end else begin
			next_count      = qat_pkg::COUNT_W'(wrapped);
			next_calibrated = calibrated_q;
		end
	end

	// Fold the count into the range -225 to 224 and look up the angle of its
	// magnitude; the sign is put back afterwards since the scaling truncates toward zero.
	always_comb begin
		folded = qat_pkg::STEP_W'(next_count);
		if (folded > qat_pkg::STEP_W'(qat_pkg::HALF_REV)) begin
			folded = folded - qat_pkg::STEP_W'(qat_pkg::COUNTS_PER_REV);
		end else if (folded < -qat_pkg::STEP_W'(qat_pkg::HALF_REV)
				- qat_pkg::STEP_W'(1)) begin
			folded = folded + qat_pkg::STEP_W'(qat_pkg::COUNTS_PER_REV);
		end
		folded_abs   = folded[qat_pkg::STEP_W-1] ? -folded : folded;
		fold_mag     = folded_abs[qat_pkg::MAG_W-1:0];
		angle_entry  = qat_pkg::ANGLE_TABLE[fold_mag];
		deg_unsigned = qat_pkg::DEGREES_W'(angle_entry.deg_mag);
		next_degrees = folded[qat_pkg::STEP_W-1] ? -deg_unsigned : deg_unsigned;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_enable_q <= 1'b1;
			prev_phase_q <= qat_pkg::PHASE_NONE;
			pos_count_q  <= '0;
			calibrated_q <= 1'b0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
		end else begin
			if (cfg_we) begin
				ref_enable_q <= cfg_wdata;
			end
			if (adv_s1) begin
				prev_phase_q <= cur_phase;
				pos_count_q  <= next_count;
				calibrated_q <= next_calibrated;
			end
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			chan_a_s1    <= chan_a;
			chan_b_s1    <= chan_b;
			ref_pulse_s1 <= ref_pulse;
		end
		if (adv_s1) begin
			position_count_s2 <= next_count;
			angle_degrees_s2  <= next_degrees;
			angle_tenths_s2   <= angle_entry.tenths;
			is_calibrated_s2  <= next_calibrated;
		end
	end

	assign out_valid      = valid_s2;
	assign position_count = position_count_s2;
	assign angle_degrees  = angle_degrees_s2;
	assign angle_tenths   = angle_tenths_s2;
	assign is_calibrated  = is_calibrated_s2;

	`QAT_ASSERT_HOLDS(a_count_range, clk, arst_n,
		!out_valid || (position_count <= 10'sd447 && position_count >= -10'sd447),
		"position count left its wrapped range")
	`QAT_ASSERT_HOLDS(a_angle_range, clk, arst_n,
		!out_valid || (angle_tenths <= 4'd9 && angle_degrees <= 9'sd180
			&& angle_degrees >= -9'sd180),
		"angle result out of range")
	`QAT_ASSERT_HOLDS(a_cal_sticky, clk, arst_n, !$fell(calibrated_q),
		"calibrated flag cleared after being set")
	`QAT_ASSERT_NEXT(a_ref_zeroes, clk, arst_n, adv_s1 && ref_pulse_s1 && ref_enable_q,
		out_valid && position_count == '0 && is_calibrated,
		"enabled reference pulse did not zero the count")

endmodule

`default_nettype wire
